// File: rtl/shbh_pkg.sv
// ----------------------------------------------------------------------------
// shbh_pkg - shared types, constants and functions of the SHA-256 hasher
// Round constants, initial hash values, sigma functions and the control
// bundle that drives the message schedule window.
// ----------------------------------------------------------------------------
package shbh_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] work_t;   // index 0 is word a / H0

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned MsgWords   = 16;
  localparam int unsigned DigestWords = 8;
  localparam int unsigned LenBits    = 61;

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LastFill  = 6'd63;
  localparam logic [5:0] PadLimit  = 6'd56;   // first byte of the length field

  localparam work_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // schedule window control, one beat of work per cycle
  typedef struct packed {
    logic       load;      // shift one byte into the window
    logic       step;      // advance one round word
    logic       use_msg;   // rounds 0..15 take the message word as is
    logic [7:0] byte_val;
  } sched_ctrl_t;

  function automatic word_t rotr(input word_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t bsig0(input word_t v);
    return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t bsig1(input word_t v);
    return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic word_t ssig0(input word_t v);
    return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t ssig1(input word_t v);
    return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

// File: rtl/sha256_byte_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_hasher - SHA-256 over a byte stream
// Byte-wide absorb/finish input, eight-beat digest output.
// ----------------------------------------------------------------------------
// Each absorb beat (tuser = 0) appends tdata[7:0] to the message. The 64th
// byte of a block starts compression: 64 rounds at one per cycle through a
// single shared round unit, then a fold of the working words into the hash.
// s_axis_tready_o is low while a block compresses or a digest is pending. A
// finish beat (tuser = 1) pads byte by byte through the same block buffer
// (0x80, zeros, 64-bit big-endian bit length) and compresses the padded
// block, or a second padded block as well when fewer than nine bytes are
// free. The digest then leaves as eight 32-bit beats, H0 first, tlast on the
// eighth; after the last beat the hash returns to the initial values and a
// new message may start. The message length counter is 61 bits and wraps.
// ----------------------------------------------------------------------------
module sha256_byte_hasher
  import shbh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] opcode: 0 absorb, 1 finish
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast_o    // last_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [5:0] LastRound = 6'(Rounds - 1);
  localparam logic [2:0] LastWord  = 3'(DigestWords - 1);

  logic [2:0]         state_q, state_d;
  logic [5:0]         fill_q, fill_d;
  logic [LenBits-1:0] len_q, len_d;
  logic [5:0]         round_q, round_d;
  logic               need_extra_q, need_extra_d;  // padding spills into a second block
  logic               finish_q, finish_d;
  logic               first_q, first_d;            // next pad byte is the marker
  logic [2:0]         idx_q, idx_d;

  work_t chain_q;
  work_t work_q;
  work_t work_next;
  word_t w_cur;

  logic        load_work;
  logic        fold;
  logic        chain_iv;
  logic        in_beat;
  sched_ctrl_t ctrl;

  logic [63:0] len_bits;
  logic [2:0]  len_sel;
  logic [7:0]  pad_byte;

  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  // length field, big-endian, bytes 56..63 of the last block
  assign len_bits = {len_q, 3'b000};
  assign len_sel  = ~fill_q[2:0];

  always_comb begin
    if (first_q) begin
      pad_byte = PadMarker;
    end else if (fill_q >= PadLimit && !need_extra_q) begin
      pad_byte = len_bits[{len_sel, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    len_d        = len_q;
    round_d      = round_q;
    need_extra_d = need_extra_q;
    finish_d     = finish_q;
    first_d      = first_q;
    idx_d        = idx_q;
    load_work    = 1'b0;
    fold         = 1'b0;
    chain_iv     = 1'b0;
    ctrl         = '0;

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (!s_axis_tuser_i) begin
            ctrl.load     = 1'b1;
            ctrl.byte_val = s_axis_tdata_i;
            fill_d        = fill_q + 6'd1;
            len_d         = len_q + LenBits'(1);
            if (fill_q == LastFill) begin
              state_d   = S_RUN;
              round_d   = '0;
              load_work = 1'b1;
              finish_d  = 1'b0;
            end
          end else begin
            state_d      = S_PAD;
            finish_d     = 1'b1;
            first_d      = 1'b1;
            need_extra_d = (fill_q >= PadLimit);
          end
        end
      end
      S_PAD: begin
        ctrl.load     = 1'b1;
        ctrl.byte_val = pad_byte;
        first_d       = 1'b0;
        fill_d        = fill_q + 6'd1;
        if (fill_q == LastFill) begin
          state_d   = S_RUN;
          round_d   = '0;
          load_work = 1'b1;
        end
      end
      S_RUN: begin
        ctrl.step    = 1'b1;
        ctrl.use_msg = (round_q[5:4] == 2'b00);
        round_d      = round_q + 6'd1;
        if (round_q == LastRound) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        fold = 1'b1;
        if (!finish_q) begin
          state_d = S_IDLE;
        end else if (need_extra_q) begin
          need_extra_d = 1'b0;
          state_d      = S_PAD;
        end else begin
          idx_d   = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (m_axis_tready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LastWord) begin
            chain_iv = 1'b1;
            len_d    = '0;
            fill_d   = '0;
            finish_d = 1'b0;
            state_d  = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      len_q        <= '0;
      round_q      <= '0;
      need_extra_q <= 1'b0;
      finish_q     <= 1'b0;
      first_q      <= 1'b0;
      idx_q        <= '0;
      chain_q      <= InitHash;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      len_q        <= len_d;
      round_q      <= round_d;
      need_extra_q <= need_extra_d;
      finish_q     <= finish_d;
      first_q      <= first_d;
      idx_q        <= idx_d;
      if (chain_iv) begin
        chain_q <= InitHash;
      end else if (fold) begin
        for (int i = 0; i < DigestWords; i++) begin
          chain_q[i] <= chain_q[i] + work_q[i];
        end
      end
    end
  end

  // working words: loaded from the hash at block start, one round per cycle
  always_ff @(posedge clk_i) begin
    if (load_work) begin
      work_q <= chain_q;
    end else if (state_q == S_RUN) begin
      work_q <= work_next;
    end
  end

  shbh_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .w_o    (w_cur)
  );

  shbh_round u_round (
    .work_i (work_q),
    .k_i    (RoundK[round_q]),
    .w_i    (w_cur),
    .work_o (work_next)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tdata_o  = {5'b00000, idx_q, chain_q[idx_q]};
  assign m_axis_tlast_o  = (idx_q == LastWord);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while digest pending");

  a_block_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && !s_axis_tuser_i && fill_q == LastFill)
      |=> (!s_axis_tready_o && state_q == S_RUN && round_q == 6'd0 && fill_q == 6'd0))
    else $error("full block did not start compression");

  a_digest_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (fill_q == 6'd0 && !need_extra_q && finish_q))
    else $error("digest shown with padding unfinished");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o)
      |=> (s_axis_tready_o && len_q == '0 && chain_q == InitHash))
    else $error("hash not reinitialized after digest");

  a_fold_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FOLD) |-> ($past(state_q) == S_RUN && $past(round_q) == LastRound))
    else $error("fold without a full set of rounds");
`endif

endmodule

// File: rtl/shbh_sched.sv
// ----------------------------------------------------------------------------
// shbh_sched - message block buffer and schedule window
// Sixteen-word shift line: bytes shift in big-endian during fill, then each
// round rotates in the next schedule word. Entry 0 holds the oldest word.
// ----------------------------------------------------------------------------
module shbh_sched
  import shbh_pkg::*;
(
  input  logic        clk_i,
  input  sched_ctrl_t ctrl_i,
  output word_t       w_o
);

  word_t win_q [MsgWords];
  word_t w_new;

  always_comb begin
    if (ctrl_i.use_msg) begin
      w_new = win_q[0];
    end else begin
      w_new = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
    end
  end

  assign w_o = w_new;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int i = 0; i < MsgWords - 1; i++) begin
        win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_q[MsgWords-1] <= {win_q[MsgWords-1][23:0], ctrl_i.byte_val};
    end else if (ctrl_i.step) begin
      for (int i = 0; i < MsgWords - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[MsgWords-1] <= w_new;
    end
  end

endmodule

// File: rtl/shbh_round.sv
// ----------------------------------------------------------------------------
// shbh_round - one SHA-256 compression round
// Shared round unit: takes the working words, round constant and schedule
// word and returns the working words after the round.
// ----------------------------------------------------------------------------
module shbh_round
  import shbh_pkg::*;
(
  input  work_t work_i,
  input  word_t k_i,
  input  word_t w_i,
  output work_t work_o
);

  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  always_comb begin
    ch  = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
    maj = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^ (work_i[1] & work_i[2]);
    t1  = work_i[7] + bsig1(work_i[4]) + ch + k_i + w_i;
    t2  = bsig0(work_i[0]) + maj;

    work_o[7] = work_i[6];
    work_o[6] = work_i[5];
    work_o[5] = work_i[4];
    work_o[4] = work_i[3] + t1;
    work_o[3] = work_i[2];
    work_o[2] = work_i[1];
    work_o[1] = work_i[0];
    work_o[0] = t1 + t2;
  end

endmodule
